// ===== design/session_context_tombstone_floor_table_macros.svh =====
// Assertion helpers shared by the table design
`ifndef SESSION_CONTEXT_TOMBSTONE_FLOOR_TABLE_MACROS_SVH
`define SESSION_CONTEXT_TOMBSTONE_FLOOR_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCFT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SCFT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SCFT_ASSERT_NOW(lbl, ante, cons, msg)
`define SCFT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/scft_pkg.sv =====
package scft_pkg;

   typedef enum logic [2:0] {
      CMD_CTX_FIND   = 3'd0,
      CMD_CTX_ALLOC  = 3'd1,
      CMD_TOMB_PUT   = 3'd2,
      CMD_TOMB_FIND  = 3'd3,
      CMD_FLOOR_PUT  = 3'd4,
      CMD_FLOOR_FIND = 3'd5,
      CMD_INVALIDATE = 3'd6,
      CMD_UNUSED     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_CAP       = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_LAST   = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   localparam int unsigned CapW     = 5;
   localparam int unsigned ReqDataW = 264;
   localparam int unsigned RspDataW = 80;
   localparam int unsigned KeyW     = 192;
   localparam logic [CapW-1:0] CapReset = 5'd4;

endpackage

// ===== design/scft_ram.sv =====
module scft_ram #(
   parameter int unsigned WIDTH = 192,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/session_context_tombstone_floor_table.sv =====
// Flow: a word is accepted only in the idle state, and the next one only after the
//    response of the last has been posted. The scan reads one entry of each table
//    memory per cycle, up to the largest of the three table depths; a last state
//    ends the compares, then the decide state does the write-back and posts the response.
// Reset: synchronous, active high; clears all valid bits, the handshake and the
//    per-signer cap (back to 4). Table memories are not cleared.
module session_context_tombstone_floor_table #(
   parameter int unsigned CONTEXT_ENTRIES   = 16,
   parameter int unsigned TOMBSTONE_ENTRIES = 16,
   parameter int unsigned FLOOR_ENTRIES     = 16,
   parameter int unsigned ID_BYTES          = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rule_id[31:0], generation[63:32], local_id[127:64], remote_id[191:128],
   // outcome[194:192], replay_mark[226:195], close_stamp[258:227]
   input  logic [263:0] req_tdata,
   // command[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], slot[5:2], removed[11:6], found_high_water[43:12],
   // found_time[75:44], found_outcome[78:76]
   output logic [79:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data
);

   localparam int unsigned ScanN0 = (CONTEXT_ENTRIES > TOMBSTONE_ENTRIES) ?
                                    CONTEXT_ENTRIES : TOMBSTONE_ENTRIES;
   localparam int unsigned ScanN  = (ScanN0 > FLOOR_ENTRIES) ? ScanN0 : FLOOR_ENTRIES;
   localparam int unsigned IdxW   = (ScanN > 1) ? $clog2(ScanN) : 1;
   localparam int unsigned CAw    = (CONTEXT_ENTRIES > 1) ? $clog2(CONTEXT_ENTRIES) : 1;
   localparam int unsigned TAw    = (TOMBSTONE_ENTRIES > 1) ? $clog2(TOMBSTONE_ENTRIES) : 1;
   localparam int unsigned FAw    = (FLOOR_ENTRIES > 1) ? $clog2(FLOOR_ENTRIES) : 1;
   localparam int unsigned CcW    = $clog2(CONTEXT_ENTRIES + 1);
   localparam int unsigned RmW    = $clog2(CONTEXT_ENTRIES + TOMBSTONE_ENTRIES +
                                           FLOOR_ENTRIES + 1);
   localparam int unsigned KW     = scft_pkg::KeyW;
   localparam int unsigned TombW  = KW + 67;
   localparam int unsigned FloorW = KW + 32;
   localparam logic [63:0] IdMask = {64{1'b1}} >> (64 - 8 * ID_BYTES);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(ScanN - 1);

   // control state
   scft_pkg::state_type state_ff, state_in;
   logic [scft_pkg::CapW-1:0] cap_ff;
   logic [IdxW-1:0] cnt_ff, cnt_in;
   logic            pv_ff;
   logic [IdxW-1:0] pidx_ff;
   logic            rsp_valid_ff;
   logic [79:0]     rsp_data_ff;

   // captured item
   scft_pkg::cmd_type cmd_ff;
   logic [63:0] rg_ff, lo_ff, re_ff;
   logic [2:0]  oc_ff;
   logic [31:0] hw_ff, tt_ff;

   // scan results
   logic            c_hit_ff, c_free_ff, t_hit_ff, t_free_ff, f_hit_ff, f_free_ff;
   logic [IdxW-1:0] c_hslot_ff, c_fslot_ff, t_hslot_ff, t_fslot_ff, t_bslot_ff;
   logic [IdxW-1:0] f_hslot_ff, f_fslot_ff, f_bslot_ff;
   logic [CcW-1:0]  c_cnt_ff;
   logic [31:0]     t_best_ff, f_best_ff, t_hhw_ff, t_htt_ff, f_hmark_ff;
   logic [2:0]      t_hoc_ff;
   logic [RmW-1:0]  rm_ff;

   logic [CONTEXT_ENTRIES-1:0]   c_vld_ff;
   logic [TOMBSTONE_ENTRIES-1:0] t_vld_ff;
   logic [FLOOR_ENTRIES-1:0]     f_vld_ff;

   // memory ports
   logic            c_we, t_we, f_we;
   logic [IdxW-1:0] c_wslot, t_wslot, f_wslot;
   logic [KW-1:0]     c_rdata;
   logic [TombW-1:0]  t_rdata, t_wdata;
   logic [FloorW-1:0] f_rdata, f_wdata;

   logic accept, fire, scanning;
   logic c_in, t_in, f_in, c_v, t_v, f_v;
   logic c_key, t_key, f_key, c_inv, t_inv, f_inv;
   logic [KW-1:0] key_w;
   logic [31:0]   t_hw_new, t_tt_new, f_mark_new;
   scft_pkg::status_type status_w;
   logic [IdxW-1:0] slot_w;
   logic [31:0] fhw_w, ftime_w;
   logic [2:0]  foc_w;
   logic [5:0]  removed_w;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == scft_pkg::ST_IDLE);
   assign fire       = (state_ff == scft_pkg::ST_DECIDE) && (!rsp_valid_ff || rsp_tready);
   assign scanning   = pv_ff;
   assign key_w      = {re_ff, lo_ff, rg_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         scft_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = scft_pkg::ST_SCAN;
            end
         end
         scft_pkg::ST_SCAN: begin
            if (cnt_ff == LastIdx) begin
               state_in = scft_pkg::ST_LAST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         scft_pkg::ST_LAST:   state_in = scft_pkg::ST_DECIDE;
         scft_pkg::ST_DECIDE: begin
            if (fire) begin
               state_in = scft_pkg::ST_IDLE;
            end
         end
         default: state_in = scft_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scft_pkg::ST_IDLE;
         cap_ff       <= scft_pkg::CapReset;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= (state_ff == scft_pkg::ST_SCAN);
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      pidx_ff <= cnt_ff;
   end

   // per-entry compare on the word read last cycle
   assign c_in  = scanning && (32'(pidx_ff) < 32'(CONTEXT_ENTRIES));
   assign t_in  = scanning && (32'(pidx_ff) < 32'(TOMBSTONE_ENTRIES));
   assign f_in  = scanning && (32'(pidx_ff) < 32'(FLOOR_ENTRIES));
   assign c_v   = c_in && c_vld_ff[pidx_ff[CAw-1:0]];
   assign t_v   = t_in && t_vld_ff[pidx_ff[TAw-1:0]];
   assign f_v   = f_in && f_vld_ff[pidx_ff[FAw-1:0]];
   assign c_key = (c_rdata == key_w);
   assign t_key = (t_rdata[KW-1:0] == key_w);
   assign f_key = (f_rdata[KW-1:0] == key_w);
   assign c_inv = (cmd_ff == scft_pkg::CMD_INVALIDATE) && c_v &&
                  (c_rdata[31:0] == rg_ff[31:0]) && (c_rdata[191:128] == re_ff);
   assign t_inv = (cmd_ff == scft_pkg::CMD_INVALIDATE) && t_v &&
                  (t_rdata[31:0] == rg_ff[31:0]) && (t_rdata[191:128] == re_ff);
   assign f_inv = (cmd_ff == scft_pkg::CMD_INVALIDATE) && f_v &&
                  (f_rdata[31:0] == rg_ff[31:0]) && (f_rdata[191:128] == re_ff);

   // item capture and scan accumulation
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= scft_pkg::cmd_type'(req_tuser);
         rg_ff     <= {req_tdata[31:0], req_tdata[63:32]};
         lo_ff     <= req_tdata[127:64] & IdMask;
         re_ff     <= req_tdata[191:128] & IdMask;
         oc_ff     <= req_tdata[194:192];
         hw_ff     <= req_tdata[226:195];
         tt_ff     <= req_tdata[258:227];
         c_hit_ff  <= 1'b0;
         c_free_ff <= 1'b0;
         c_cnt_ff  <= '0;
         t_hit_ff  <= 1'b0;
         t_free_ff <= 1'b0;
         t_best_ff <= '1;
         t_bslot_ff <= '0;
         f_hit_ff  <= 1'b0;
         f_free_ff <= 1'b0;
         f_best_ff <= '1;
         f_bslot_ff <= '0;
         rm_ff     <= '0;
      end else if (scanning) begin
         if (c_v && c_key && !c_hit_ff) begin
            c_hit_ff   <= 1'b1;
            c_hslot_ff <= pidx_ff;
         end
         if (c_v && (c_rdata[191:128] == re_ff)) begin
            c_cnt_ff <= c_cnt_ff + 1'b1;
         end
         if (c_in && !c_v && !c_free_ff) begin
            c_free_ff  <= 1'b1;
            c_fslot_ff <= pidx_ff;
         end
         if (t_v && t_key && !t_hit_ff) begin
            t_hit_ff   <= 1'b1;
            t_hslot_ff <= pidx_ff;
            t_htt_ff   <= t_rdata[KW+31:KW];
            t_hhw_ff   <= t_rdata[KW+63:KW+32];
            t_hoc_ff   <= t_rdata[KW+66:KW+64];
         end
         if (t_in && !t_v && !t_free_ff) begin
            t_free_ff  <= 1'b1;
            t_fslot_ff <= pidx_ff;
         end
         if (t_v && (t_rdata[KW+31:KW] < t_best_ff)) begin
            t_best_ff  <= t_rdata[KW+31:KW];
            t_bslot_ff <= pidx_ff;
         end
         if (f_v && f_key && !f_hit_ff) begin
            f_hit_ff   <= 1'b1;
            f_hslot_ff <= pidx_ff;
            f_hmark_ff <= f_rdata[KW+31:KW];
         end
         if (f_in && !f_v && !f_free_ff) begin
            f_free_ff  <= 1'b1;
            f_fslot_ff <= pidx_ff;
         end
         if (f_v && (f_rdata[KW+31:KW] < f_best_ff)) begin
            f_best_ff  <= f_rdata[KW+31:KW];
            f_bslot_ff <= pidx_ff;
         end
         rm_ff <= rm_ff + RmW'(c_inv) + RmW'(t_inv) + RmW'(f_inv);
      end
   end

   // decision and write-back
   assign t_hw_new   = (hw_ff > t_hhw_ff) ? hw_ff : t_hhw_ff;
   assign t_tt_new   = (tt_ff > t_htt_ff) ? tt_ff : t_htt_ff;
   assign f_mark_new = (hw_ff > f_hmark_ff) ? hw_ff : f_hmark_ff;

   always_comb begin
      status_w  = scft_pkg::STS_OK;
      slot_w    = '0;
      fhw_w     = '0;
      ftime_w   = '0;
      foc_w     = '0;
      removed_w = '0;
      c_we      = 1'b0;
      t_we      = 1'b0;
      f_we      = 1'b0;
      c_wslot   = c_fslot_ff;
      t_wslot   = t_hslot_ff;
      f_wslot   = f_hslot_ff;
      t_wdata   = {oc_ff, hw_ff, tt_ff, key_w};
      f_wdata   = {hw_ff, key_w};
      unique case (cmd_ff)
         scft_pkg::CMD_CTX_FIND: begin
            if (c_hit_ff) begin
               slot_w = c_hslot_ff;
            end else begin
               status_w = scft_pkg::STS_NOT_FOUND;
            end
         end
         scft_pkg::CMD_CTX_ALLOC: begin
            if (c_hit_ff) begin
               slot_w = c_hslot_ff;
            end else if (32'(c_cnt_ff) >= 32'(cap_ff)) begin
               status_w = scft_pkg::STS_CAP;
            end else if (!c_free_ff) begin
               status_w = scft_pkg::STS_FULL;
            end else begin
               slot_w = c_fslot_ff;
               c_we   = fire;
            end
         end
         scft_pkg::CMD_TOMB_PUT: begin
            t_we = fire;
            if (t_hit_ff) begin
               t_wdata = {oc_ff, t_hw_new, t_tt_new, key_w};
            end else if (t_free_ff) begin
               t_wslot = t_fslot_ff;
            end else begin
               t_wslot = t_bslot_ff;
            end
            slot_w = t_wslot;
         end
         scft_pkg::CMD_TOMB_FIND: begin
            if (t_hit_ff) begin
               slot_w  = t_hslot_ff;
               fhw_w   = t_hhw_ff;
               ftime_w = t_htt_ff;
               foc_w   = t_hoc_ff;
            end else begin
               status_w = scft_pkg::STS_NOT_FOUND;
            end
         end
         scft_pkg::CMD_FLOOR_PUT: begin
            f_we = fire;
            if (f_hit_ff) begin
               f_wdata = {f_mark_new, key_w};
            end else if (f_free_ff) begin
               f_wslot = f_fslot_ff;
            end else begin
               f_wslot = f_bslot_ff;
            end
            slot_w = f_wslot;
         end
         scft_pkg::CMD_FLOOR_FIND: begin
            if (f_hit_ff) begin
               slot_w = f_hslot_ff;
               fhw_w  = f_hmark_ff;
            end else begin
               status_w = scft_pkg::STS_NOT_FOUND;
            end
         end
         scft_pkg::CMD_INVALIDATE: removed_w = 6'(rm_ff);
         default: status_w = scft_pkg::STS_NOT_FOUND;
      endcase
   end

   // valid bits: cleared by invalidate during the scan, set on write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= '0;
         t_vld_ff <= '0;
         f_vld_ff <= '0;
      end else begin
         if (c_inv) c_vld_ff[pidx_ff[CAw-1:0]] <= 1'b0;
         if (t_inv) t_vld_ff[pidx_ff[TAw-1:0]] <= 1'b0;
         if (f_inv) f_vld_ff[pidx_ff[FAw-1:0]] <= 1'b0;
         if (c_we) c_vld_ff[c_wslot[CAw-1:0]] <= 1'b1;
         if (t_we) t_vld_ff[t_wslot[TAw-1:0]] <= 1'b1;
         if (f_we) f_vld_ff[f_wslot[FAw-1:0]] <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {1'b0, foc_w, ftime_w, fhw_w, removed_w, 4'(slot_w), status_w};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   scft_ram #(.WIDTH(KW), .DEPTH(CONTEXT_ENTRIES)) u_ctx_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_wslot[CAw-1:0]),
      .wdata (key_w),
      .raddr (cnt_ff[CAw-1:0]),
      .rdata (c_rdata)
   );

   scft_ram #(.WIDTH(TombW), .DEPTH(TOMBSTONE_ENTRIES)) u_tomb_ram (
      .clock (clock),
      .we    (t_we),
      .waddr (t_wslot[TAw-1:0]),
      .wdata (t_wdata),
      .raddr (cnt_ff[TAw-1:0]),
      .rdata (t_rdata)
   );

   scft_ram #(.WIDTH(FloorW), .DEPTH(FLOOR_ENTRIES)) u_floor_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_wslot[FAw-1:0]),
      .wdata (f_wdata),
      .raddr (cnt_ff[FAw-1:0]),
      .rdata (f_rdata)
   );

`include "session_context_tombstone_floor_table_macros.svh"

   `SCFT_ASSERT_NEXT(a_accept_scans, accept, state_ff == scft_pkg::ST_SCAN,
      "accept did not start scan")
   `SCFT_ASSERT_NOW(a_write_in_decide, c_we || t_we || f_we, fire,
      "table write outside write-back")
   `SCFT_ASSERT_NOW(a_removed_only_inv,
      state_ff == scft_pkg::ST_DECIDE && cmd_ff != scft_pkg::CMD_INVALIDATE,
      rm_ff == '0, "removed count without invalidate")
   `SCFT_ASSERT_NEXT(a_fire_valid, fire, rsp_valid_ff && state_ff == scft_pkg::ST_IDLE,
      "response not posted")

endmodule

// ===== tb/tb_table_checker.sv =====
module tb_table_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [263:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data,
   output int           fail_count,
   output int           pending,
   output int           rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 16;

   typedef struct packed {
      logic [2:0]  foc;
      logic [31:0] ftime;
      logic [31:0] fhw;
      logic [5:0]  removed;
      logic [3:0]  slot;
      logic [1:0]  status;
   } rsp_type;

   // shadow of the tables
   logic [4:0]   cap;
   logic         cv [Depth];
   logic [191:0] ck [Depth];
   logic         tv [Depth];
   logic [191:0] tk [Depth];
   logic [31:0]  thw [Depth];
   logic [31:0]  ttm [Depth];
   logic [2:0]   toc [Depth];
   logic         fv [Depth];
   logic [191:0] fk [Depth];
   logic [31:0]  fmk [Depth];
   rsp_type      expected_q[$];

   function automatic rsp_type table_step(input logic [263:0] d, input logic [2:0] c);
      rsp_type r;
      logic [191:0] key;
      logic [31:0] gen, hw, tt, best;
      logic [63:0] re;
      int s, cnt, used;
      r = '0;
      key = d[191:0];
      gen = d[63:32];
      re = d[191:128];
      hw = d[226:195];
      tt = d[258:227];
      s = -1;
      cnt = 0;
      used = 0;
      case (c) inside
         scft_pkg::CMD_CTX_FIND, scft_pkg::CMD_CTX_ALLOC: begin
            for (int i = 0; i < Depth; i++)
               if (s < 0 && cv[i] && ck[i] == key) s = i;
            if (s >= 0) r.slot = 4'(s);
            else if (c == scft_pkg::CMD_CTX_FIND) r.status = scft_pkg::STS_NOT_FOUND;
            else begin
               for (int i = 0; i < Depth; i++)
                  if (cv[i] && ck[i][191:128] == re) cnt++;
               if (cnt >= cap) r.status = scft_pkg::STS_CAP;
               else begin
                  r.status = scft_pkg::STS_FULL;
                  for (int i = 0; i < Depth; i++)
                     if (s < 0 && !cv[i]) s = i;
                  if (s >= 0) begin
                     cv[s] = 1'b1;
                     ck[s] = key;
                     r.status = scft_pkg::STS_OK;
                     r.slot = 4'(s);
                  end
               end
            end
         end
         scft_pkg::CMD_TOMB_PUT: begin
            for (int i = 0; i < Depth; i++)
               if (s < 0 && tv[i] && tk[i] == key) s = i;
            if (s >= 0) begin
               if (hw > thw[s]) thw[s] = hw;
               if (tt > ttm[s]) ttm[s] = tt;
               toc[s] = d[194:192];
            end else begin
               for (int i = 0; i < Depth; i++)
                  if (s < 0 && !tv[i]) s = i;
               // full: evict oldest time, lowest index on ties
               if (s < 0) begin
                  best = '1;
                  s = 0;
                  for (int i = 0; i < Depth; i++)
                     if (ttm[i] < best) begin
                        best = ttm[i];
                        s = i;
                     end
               end
               tv[s] = 1'b1;
               tk[s] = key;
               thw[s] = hw;
               ttm[s] = tt;
               toc[s] = d[194:192];
            end
            r.slot = 4'(s);
         end
         scft_pkg::CMD_TOMB_FIND: begin
            for (int i = 0; i < Depth; i++)
               if (s < 0 && tv[i] && tk[i] == key) s = i;
            if (s < 0) r.status = scft_pkg::STS_NOT_FOUND;
            else begin
               r.slot = 4'(s);
               r.fhw = thw[s];
               r.ftime = ttm[s];
               r.foc = toc[s];
            end
         end
         scft_pkg::CMD_FLOOR_PUT: begin
            for (int i = 0; i < Depth; i++)
               if (s < 0 && fv[i] && fk[i] == key) s = i;
            if (s >= 0) begin
               if (hw > fmk[s]) fmk[s] = hw;
            end else begin
               for (int i = 0; i < Depth; i++)
                  if (s < 0 && !fv[i]) s = i;
               // full: evict lowest mark
               if (s < 0) begin
                  best = '1;
                  s = 0;
                  for (int i = 0; i < Depth; i++)
                     if (fmk[i] < best) begin
                        best = fmk[i];
                        s = i;
                     end
               end
               fv[s] = 1'b1;
               fk[s] = key;
               fmk[s] = hw;
            end
            r.slot = 4'(s);
         end
         scft_pkg::CMD_FLOOR_FIND: begin
            for (int i = 0; i < Depth; i++)
               if (s < 0 && fv[i] && fk[i] == key) s = i;
            if (s < 0) r.status = scft_pkg::STS_NOT_FOUND;
            else begin
               r.slot = 4'(s);
               r.fhw = fmk[s];
            end
         end
         scft_pkg::CMD_INVALIDATE: begin
            for (int i = 0; i < Depth; i++) begin
               if (cv[i] && ck[i][63:32] == gen && ck[i][191:128] == re) begin
                  cv[i] = 1'b0;
                  used++;
               end
               if (tv[i] && tk[i][63:32] == gen && tk[i][191:128] == re) begin
                  tv[i] = 1'b0;
                  used++;
               end
               if (fv[i] && fk[i][63:32] == gen && fk[i][191:128] == re) begin
                  fv[i] = 1'b0;
                  used++;
               end
            end
            r.removed = 6'(used);
         end
         default: r.status = scft_pkg::STS_NOT_FOUND;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         cap <= scft_pkg::CapReset;
         for (int i = 0; i < Depth; i++) begin
            cv[i] = 1'b0;
            tv[i] = 1'b0;
            fv[i] = 1'b0;
         end
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
         rsp_count <= 0;
      end else begin
         if (csr_wr_en) cap <= csr_wr_data;
         if (req_tvalid && req_tready)
            expected_q.push_back(table_step(req_tdata, req_tuser));
         // compare the word leaving the block
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            got = rsp_tdata[78:0];
            if (expected_q.size() == 0) begin
               $error("response word with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got != want) begin
                  fail_count <= fail_count + 1;
                  if (got.status != want.status)
                     $error("status: expected %0d actual %0d", want.status, got.status);
                  if (got.slot != want.slot)
                     $error("slot: expected %0d actual %0d", want.slot, got.slot);
                  if (got.removed != want.removed)
                     $error("removed: expected %0d actual %0d", want.removed, got.removed);
                  if (got.fhw != want.fhw)
                     $error("found_high_water: expected %h actual %h", want.fhw, got.fhw);
                  if (got.ftime != want.ftime)
                     $error("found_time: expected %h actual %h", want.ftime, got.ftime);
                  if (got.foc != want.foc)
                     $error("found_outcome: expected %0d actual %0d", want.foc, got.foc);
               end
            end
         end
         pending <= expected_q.size();
      end
   end
endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [263:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [4:0]   csr_wr_data = '0;
   int           fail_count, pending, rsp_count;
   int           idle_cycles = 0;
   bit           hold_rsp = 1'b0;

   // small pools so keys collide and tables fill
   logic [31:0]  rule_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
   logic [31:0]  gen_pool  [3] = '{32'h0, 32'hFFFF_FFFF, 32'h5A5A_A5A5};
   logic [63:0]  id_pool   [4] = '{64'h0, '1, 64'hDEAD_BEEF_0BAD_F00D, 64'h2};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   session_context_tombstone_floor_table dut (.*);

   tb_table_checker u_chk (.*);

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else case ($urandom_range(3))
         0: rsp_tready <= ($urandom_range(4) == 0);
         default: rsp_tready <= ($urandom_range(9) != 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(input logic [2:0] c, input logic [263:0] d);
      req_tvalid <= 1'b1;
      req_tuser <= c;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_gap(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [263:0] pack_req(input logic [31:0] rule, gen,
         input logic [63:0] loc, rem, input logic [2:0] oc, input logic [31:0] hw, tt);
      return {5'b0, tt, hw, oc, rem, loc, gen, rule};
   endfunction

   function automatic logic [263:0] rand_req(input bit noise);
      logic [31:0] a, b, h, t;
      logic [63:0] l, r;
      if (noise) begin
         a = $urandom; b = $urandom; l = {$urandom, $urandom}; r = {$urandom, $urandom};
      end else begin
         a = rule_pool[$urandom_range(3)]; b = gen_pool[$urandom_range(2)];
         l = id_pool[$urandom_range(1)]; r = id_pool[$urandom_range(3)];
      end
      h = ($urandom_range(3) == 0) ? ($urandom_range(1) ? '1 : '0) : $urandom;
      t = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom;
      return pack_req(a, b, l, r, $urandom_range(7), h, t);
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_cap(input logic [4:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int n);
      int left;
      left = n;
      while (left > 0) begin
         for (int k = $urandom_range(12, 1); k > 0 && left > 0; k--) begin
            send_word(($urandom_range(19) == 0) ? scft_pkg::CMD_UNUSED :
                      3'($urandom_range(6)), rand_req($urandom_range(9) == 0));
            left--;
         end
         if ($urandom_range(2) != 0) idle_gap($urandom_range(25));
      end
   endtask

   initial begin
      logic [263:0] k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command, extremes, cap-first, unknown command
      k = pack_req('1, '1, '1, '1, 3'd7, '1, '1);
      send_word(scft_pkg::CMD_CTX_FIND, k);
      send_word(scft_pkg::CMD_CTX_ALLOC, k);
      send_word(scft_pkg::CMD_CTX_ALLOC, k);
      send_word(scft_pkg::CMD_CTX_FIND, k);
      send_word(scft_pkg::CMD_TOMB_PUT, k);
      send_word(scft_pkg::CMD_TOMB_PUT, pack_req('1, '1, '1, '1, 3'd0, '0, '0));
      send_word(scft_pkg::CMD_TOMB_FIND, k);
      send_word(scft_pkg::CMD_FLOOR_PUT, k);
      send_word(scft_pkg::CMD_FLOOR_FIND, k);
      send_word(scft_pkg::CMD_UNUSED, k);
      send_word(scft_pkg::CMD_INVALIDATE, k);
      send_word(scft_pkg::CMD_TOMB_FIND, k);
      for (int i = 0; i < 6; i++)
         send_word(scft_pkg::CMD_CTX_ALLOC, pack_req(i, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 18; i++)
         send_word(scft_pkg::CMD_TOMB_PUT, pack_req(i, 1, 0, 0, 0, i, 5));
      drain();

      // cap of zero: every new alloc refused
      write_cap(5'd0);
      send_word(scft_pkg::CMD_CTX_ALLOC, pack_req(1, 2, 3, 4, 0, 0, 0));
      send_word(scft_pkg::CMD_CTX_ALLOC, pack_req(0, 0, 0, 0, 0, 0, 0));
      drain();

      // random phases across cap settings; long receiver hold in the first
      foreach (rule_pool[p]) begin
         case (p)
            0: write_cap(5'd16);
            1: write_cap(5'd31);
            2: write_cap(5'd1);
            default: write_cap(5'($urandom_range(1, 8)));
         endcase
         if (p == 0) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 1'b0;
               end
               random_phase(300);
            join
         end else random_phase(300);
         drain();
      end

      $display("Covered: directed edge cases, cap values 0/1/16/31 and random,");
      $display("  %0d responses checked with bursty sender and stalling receiver.", rsp_count);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/scft_pkg.sv
design/scft_ram.sv
design/session_context_tombstone_floor_table.sv
tb/tb_table_checker.sv
tb/tb.sv
